// ===== src/mie_pkg.sv =====
package mie_pkg;

    localparam logic [31:0] StartPcReset   = 32'hBFC0_0000;
    localparam logic [31:0] PcRegionMask   = 32'hF000_0000;
    localparam logic [31:0] UpperHalfMask  = 32'hFFFF_0000;
    localparam int          HalfShift      = 16;

    localparam logic [1:0] MemNone  = 2'd0;
    localparam logic [1:0] MemRead  = 2'd1;
    localparam logic [1:0] MemWrite = 2'd2;

    localparam logic [1:0] SizeByte = 2'd0;
    localparam logic [1:0] SizeHalf = 2'd1;
    localparam logic [1:0] SizeWord = 2'd2;

    localparam logic [1:0] StDone    = 2'd0;
    localparam logic [1:0] StPending = 2'd1;
    localparam logic [1:0] StUnimpl  = 2'd2;
    localparam logic [1:0] StNoLoad  = 2'd3;

    localparam logic [1:0] LkWord  = 2'd0;
    localparam logic [1:0] LkSHalf = 2'd1;
    localparam logic [1:0] LkUHalf = 2'd2;
    localparam logic [1:0] LkUByte = 2'd3;

    localparam logic [5:0] OpSpecial = 6'h00;
    localparam logic [5:0] OpRegimm  = 6'h01;
    localparam logic [5:0] OpJ       = 6'h02;
    localparam logic [5:0] OpJal     = 6'h03;
    localparam logic [5:0] OpBeq     = 6'h04;
    localparam logic [5:0] OpBne     = 6'h05;
    localparam logic [5:0] OpBlez    = 6'h06;
    localparam logic [5:0] OpAddiu   = 6'h09;
    localparam logic [5:0] OpSlti    = 6'h0A;
    localparam logic [5:0] OpSltiu   = 6'h0B;
    localparam logic [5:0] OpAndi    = 6'h0C;
    localparam logic [5:0] OpOri     = 6'h0D;
    localparam logic [5:0] OpLui     = 6'h0F;
    localparam logic [5:0] OpLh      = 6'h21;
    localparam logic [5:0] OpLw      = 6'h23;
    localparam logic [5:0] OpLbu     = 6'h24;
    localparam logic [5:0] OpLhu     = 6'h25;
    localparam logic [5:0] OpSb      = 6'h28;
    localparam logic [5:0] OpSh      = 6'h29;
    localparam logic [5:0] OpSw      = 6'h2B;

    localparam logic [5:0] FnSll   = 6'h00;
    localparam logic [5:0] FnSrl   = 6'h02;
    localparam logic [5:0] FnSra   = 6'h03;
    localparam logic [5:0] FnJr    = 6'h08;
    localparam logic [5:0] FnMfhi  = 6'h10;
    localparam logic [5:0] FnMflo  = 6'h12;
    localparam logic [5:0] FnMult  = 6'h18;
    localparam logic [5:0] FnMultu = 6'h19;
    localparam logic [5:0] FnDiv   = 6'h1A;
    localparam logic [5:0] FnAddu  = 6'h21;
    localparam logic [5:0] FnSubu  = 6'h23;
    localparam logic [5:0] FnAnd   = 6'h24;
    localparam logic [5:0] FnOr    = 6'h25;
    localparam logic [5:0] FnSlt   = 6'h2A;
    localparam logic [5:0] FnSltu  = 6'h2B;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EXEC,
        S_MUL,
        S_DIV,
        S_DIVFIX,
        S_WB,
        S_OUT
    } t_state;

endpackage

// ===== src/mips1_integer_execute.sv =====
// Channel   | Dir | Group          | Payload
// ----------+-----+----------------+------------------------------------------
// input     | in  | i_s_axis_*     | tuser: action; tdata: instr_word, load_data
// result    | out | o_m_axis_*     | tdata: next_pc..status (see port comment)
// config    | in  | APB p*         | start_pc at address 0
//
// Each item passes register file read, execute, writeback and output before
// the result transfer; the core then returns to idle to take the next one.
// MULT/MULTU add a step for each of the four 16x16 partial products; DIV
// with a nonzero divisor and no overflow runs a radix-2 loop of 32 steps.
// After reset all 32 registers of the register file are swept to zero; no transfer
// is accepted then. A stalled output holds the core; input is taken only idle.
module mips1_integer_execute
    import mie_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         i_s_axis_tready,
    input  logic [63:0]  i_s_axis_tdata,   // [31:0] instr_word, [63:32] load_data
    input  logic         i_s_axis_tuser,   // action
    output logic         o_m_axis_tvalid,
    input  logic         o_m_axis_tready,
    // [31:0] next_pc, [33:32] mem_op, [35:34] mem_size, [67:36] mem_addr,
    // [99:68] mem_wdata, [100] wb_valid, [105:101] wb_reg, [137:106] wb_value,
    // [139:138] status, [143:140] zero
    output logic [143:0] o_m_axis_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [1:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    t_state r_state, n_state;

    logic [31:0] r_gpr [32];
    logic [31:0] r_rda, r_rdb;
    logic [4:0]  r_clr;

    logic [31:0] r_start_pc, r_pc, r_hi, r_lo;
    logic        r_ld_pend;
    logic [4:0]  r_ld_dest;
    logic [1:0]  r_ld_kind;

    logic        r_act;
    logic [31:0] r_ins, r_ldata;

    // result fields
    logic [31:0] r_npc, r_maddr, r_wdata, r_wbv;
    logic [1:0]  r_mop, r_msize, r_stat;
    logic        r_wbvld;
    logic [4:0]  r_wbr;

    // multiply / divide
    logic [31:0] r_ma, r_mb;
    logic        r_mneg;
    logic [63:0] r_acc;
    logic [1:0]  r_mstep;
    logic [31:0] r_quo, r_rem, r_dvs;
    logic        r_qneg, r_rneg;
    logic [5:0]  r_dcnt;

    logic        cfg_wr;
    logic        in_xfer;
    logic [4:0]  rs, rt, rd;
    logic [5:0]  opc, fn;

    assign pready  = 1'b1;
    assign prdata  = (paddr == 2'd0) ? r_start_pc : 32'd0;
    assign cfg_wr  = psel & penable & pwrite & pready & (paddr == 2'd0);
    assign i_s_axis_tready = (r_state == S_IDLE);
    assign in_xfer = i_s_axis_tvalid & i_s_axis_tready;
    assign o_m_axis_tvalid = (r_state == S_OUT);
    assign o_m_axis_tdata = {4'd0, r_stat, r_wbv, r_wbr, r_wbvld, r_wdata, r_maddr,
                             r_msize, r_mop, r_npc};

    assign opc = r_ins[31:26];
    assign fn  = r_ins[5:0];
    assign rs  = r_ins[25:21];
    assign rt  = r_ins[20:16];
    assign rd  = r_ins[15:11];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    logic div_done;
    assign div_done = (r_dcnt == 6'd32);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:  if (r_clr == 5'd31) n_state = S_IDLE;
            S_IDLE:   if (in_xfer) n_state = S_READ;
            S_READ:   n_state = S_EXEC;
            S_EXEC: begin
                n_state = S_WB;
                if (!r_act && !r_ld_pend && opc == OpSpecial) begin
                    if (fn == FnMult || fn == FnMultu) n_state = S_MUL;
                    else if (fn == FnDiv && r_rdb != 32'd0 &&
                             !(r_rda == 32'h8000_0000 && r_rdb == 32'hFFFF_FFFF))
                        n_state = S_DIV;
                end
            end
            S_MUL:    if (r_mstep == 2'd3) n_state = S_WB;
            S_DIV:    if (div_done) n_state = S_DIVFIX;
            S_DIVFIX: n_state = S_WB;
            S_WB:     n_state = S_OUT;
            S_OUT:    if (o_m_axis_tready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // register file: synchronous read in S_IDLE, write in S_WB or clear sweep
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_rda <= r_gpr[i_s_axis_tdata[25:21]];
            r_rdb <= r_gpr[i_s_axis_tdata[20:16]];
        end
        if (r_state == S_CLEAR) begin
            r_gpr[r_clr] <= 32'd0;
        end else if (r_state == S_WB && r_wbvld) begin
            r_gpr[r_wbr] <= r_wbv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_clr <= 5'd0;
        else if (r_state == S_CLEAR) r_clr <= r_clr + 5'd1;
    end

    // execute datapath
    logic [31:0] a, b, simm, zimm, pc4, btgt, jtgt, eaddr;
    assign a    = (rs == 5'd0) ? 32'd0 : r_rda;
    assign b    = (rt == 5'd0) ? 32'd0 : r_rdb;
    assign zimm = {16'd0, r_ins[15:0]};
    assign simm = {{16{r_ins[15]}}, r_ins[15:0]};
    assign pc4  = r_pc + 32'd4;
    assign btgt = pc4 + {simm[29:0], 2'b00};
    assign jtgt = (pc4 & PcRegionMask) | {4'd0, r_ins[25:0], 2'b00};
    assign eaddr = a + simm;

    logic        x_ok, x_wb;
    logic [4:0]  x_wbr;
    logic [31:0] x_wbv, x_npc;
    always_comb begin
        x_ok  = 1'b1;
        x_wb  = 1'b0;
        x_wbr = rd;
        x_wbv = 32'd0;
        x_npc = pc4;
        unique case (opc)
            OpSpecial: begin
                case (fn)
                    FnSll:  begin x_wb = 1'b1; x_wbv = b << r_ins[10:6]; end
                    FnSrl:  begin x_wb = 1'b1; x_wbv = b >> r_ins[10:6]; end
                    FnSra:  begin x_wb = 1'b1; x_wbv = $unsigned($signed(b) >>> r_ins[10:6]); end
                    FnJr:   x_npc = a;
                    FnMfhi: begin x_wb = 1'b1; x_wbv = r_hi; end
                    FnMflo: begin x_wb = 1'b1; x_wbv = r_lo; end
                    FnMult, FnMultu, FnDiv: ;
                    FnAddu: begin x_wb = 1'b1; x_wbv = a + b; end
                    FnSubu: begin x_wb = 1'b1; x_wbv = a - b; end
                    FnAnd:  begin x_wb = 1'b1; x_wbv = a & b; end
                    FnOr:   begin x_wb = 1'b1; x_wbv = a | b; end
                    FnSlt:  begin x_wb = 1'b1; x_wbv = {31'd0, $signed(a) < $signed(b)}; end
                    FnSltu: begin x_wb = 1'b1; x_wbv = {31'd0, a < b}; end
                    default: x_ok = 1'b0;
                endcase
            end
            OpRegimm: begin
                if (rt == 5'd1) begin
                    if (!a[31]) x_npc = btgt;
                end else x_ok = 1'b0;
            end
            OpJ:    x_npc = jtgt;
            OpJal:  begin x_wb = 1'b1; x_wbr = 5'd31; x_wbv = r_pc + 32'd8; x_npc = jtgt; end
            OpBeq:  if (a == b) x_npc = btgt;
            OpBne:  if (a != b) x_npc = btgt;
            OpBlez: if (a == 32'd0 || a[31]) x_npc = btgt;
            OpAddiu: begin x_wb = 1'b1; x_wbr = rt; x_wbv = a + simm; end
            OpSlti:  begin x_wb = 1'b1; x_wbr = rt; x_wbv = {31'd0, $signed(a) < $signed(simm)}; end
            OpSltiu: begin x_wb = 1'b1; x_wbr = rt; x_wbv = {31'd0, a < simm}; end
            OpAndi:  begin x_wb = 1'b1; x_wbr = rt; x_wbv = a & zimm; end
            OpOri:   begin x_wb = 1'b1; x_wbr = rt; x_wbv = a | zimm; end
            OpLui:   begin x_wb = 1'b1; x_wbr = rt;
                           x_wbv = (zimm << HalfShift) & UpperHalfMask; end
            OpLh, OpLw, OpLbu, OpLhu, OpSb, OpSh, OpSw: ;
            default: x_ok = 1'b0;
        endcase
    end

    logic [31:0] ld_ext;
    always_comb begin
        case (r_ld_kind)
            LkWord:  ld_ext = r_ldata;
            LkSHalf: ld_ext = {{16{r_ldata[15]}}, r_ldata[15:0]};
            LkUHalf: ld_ext = {16'd0, r_ldata[15:0]};
            default: ld_ext = {24'd0, r_ldata[7:0]};
        endcase
    end

    // multiply: 4 partial products of 16x16 on magnitudes
    logic [31:0] pp;
    logic [15:0] pa, pb;
    logic [5:0]  pp_amt;
    logic [63:0] pp_sh, prod;
    assign pa = r_mstep[0] ? r_ma[31:16] : r_ma[15:0];
    assign pb = r_mstep[1] ? r_mb[31:16] : r_mb[15:0];
    assign pp = pa * pb;
    assign pp_amt = ({5'd0, r_mstep[0]} + {5'd0, r_mstep[1]}) << 4;
    assign pp_sh = {32'd0, pp} << pp_amt;
    assign prod = r_mneg ? (~(r_acc + pp_sh) + 64'd1) : (r_acc + pp_sh);

    // restoring divide on magnitudes
    logic [32:0] dtrial;
    assign dtrial = {r_rem, r_quo[31]} - {1'b0, r_dvs};

    logic [31:0] amag, bmag;
    assign amag = a[31] ? (~a + 32'd1) : a;
    assign bmag = b[31] ? (~b + 32'd1) : b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_pc <= StartPcReset;
            r_pc       <= StartPcReset;
            r_hi       <= 32'd0;
            r_lo       <= 32'd0;
            r_ld_pend  <= 1'b0;
            r_ld_dest  <= 5'd0;
            r_ld_kind  <= LkWord;
        end else begin
            if (cfg_wr) begin
                r_start_pc <= pwdata;
                r_pc       <= pwdata;
            end
            if (r_state == S_EXEC) begin
                if (r_act) begin
                    if (r_ld_pend) r_ld_pend <= 1'b0;
                end else if (!r_ld_pend) begin
                    r_pc <= x_ok ? x_npc : r_pc;
                    if (opc == OpLh || opc == OpLw || opc == OpLbu || opc == OpLhu) begin
                        r_ld_pend <= 1'b1;
                        r_ld_dest <= rt;
                        r_ld_kind <= (opc == OpLw) ? LkWord : (opc == OpLh) ? LkSHalf :
                                     (opc == OpLhu) ? LkUHalf : LkUByte;
                    end
                    if (opc == OpSpecial && fn == FnDiv) begin
                        if (b == 32'd0) begin
                            r_lo <= a[31] ? 32'd1 : 32'hFFFF_FFFF;
                            r_hi <= a;
                        end else if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) begin
                            r_lo <= 32'h8000_0000;
                            r_hi <= 32'd0;
                        end
                    end
                end
            end
            if (r_state == S_MUL && r_mstep == 2'd3) begin
                r_hi <= prod[63:32];
                r_lo <= prod[31:0];
            end
            if (r_state == S_DIVFIX) begin
                r_lo <= r_qneg ? (~r_quo + 32'd1) : r_quo;
                r_hi <= r_rneg ? (~r_rem + 32'd1) : r_rem;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_act   <= i_s_axis_tuser;
            r_ins   <= i_s_axis_tdata[31:0];
            r_ldata <= i_s_axis_tdata[63:32];
        end
        unique case (r_state)
            S_EXEC: begin
                r_mop   <= MemNone;
                r_msize <= SizeByte;
                r_maddr <= 32'd0;
                r_wdata <= 32'd0;
                r_wbvld <= 1'b0;
                r_wbr   <= 5'd0;
                r_wbv   <= 32'd0;
                r_stat  <= StDone;
                r_acc   <= 64'd0;
                r_mstep <= 2'd0;
                r_dcnt  <= 6'd0;
                r_ma    <= (fn == FnMult) ? amag : a;
                r_mb    <= (fn == FnMult) ? bmag : b;
                r_mneg  <= (fn == FnMult) & (a[31] ^ b[31]);
                r_quo   <= amag;
                r_rem   <= 32'd0;
                r_dvs   <= bmag;
                r_qneg  <= a[31] ^ b[31];
                r_rneg  <= a[31];
                if (r_act) begin
                    if (!r_ld_pend) r_stat <= StNoLoad;
                    else if (r_ld_dest != 5'd0) begin
                        r_wbvld <= 1'b1;
                        r_wbr   <= r_ld_dest;
                        r_wbv   <= ld_ext;
                    end
                end else if (r_ld_pend) begin
                    r_stat <= StPending;
                end else if (!x_ok) begin
                    r_stat <= StUnimpl;
                end else begin
                    if (x_wb && x_wbr != 5'd0) begin
                        r_wbvld <= 1'b1;
                        r_wbr   <= x_wbr;
                        r_wbv   <= x_wbv;
                    end
                    case (opc)
                        OpLh, OpLw, OpLbu, OpLhu: begin
                            r_mop   <= MemRead;
                            r_msize <= (opc == OpLw) ? SizeWord :
                                       (opc == OpLbu) ? SizeByte : SizeHalf;
                            r_maddr <= eaddr;
                            r_stat  <= StPending;
                        end
                        OpSb: begin r_mop <= MemWrite; r_msize <= SizeByte;
                                    r_maddr <= eaddr; r_wdata <= {24'd0, b[7:0]}; end
                        OpSh: begin r_mop <= MemWrite; r_msize <= SizeHalf;
                                    r_maddr <= eaddr; r_wdata <= {16'd0, b[15:0]}; end
                        OpSw: begin r_mop <= MemWrite; r_msize <= SizeWord;
                                    r_maddr <= eaddr; r_wdata <= b; end
                        default: ;
                    endcase
                end
            end
            S_MUL: begin
                r_acc   <= r_acc + pp_sh;
                r_mstep <= r_mstep + 2'd1;
            end
            S_DIV: begin
                if (!div_done) begin
                    r_dcnt <= r_dcnt + 6'd1;
                    if (!dtrial[32]) begin
                        r_rem <= dtrial[31:0];
                        r_quo <= {r_quo[30:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[30:0], r_quo[31]};
                        r_quo <= {r_quo[30:0], 1'b0};
                    end
                end
            end
            S_WB: r_npc <= r_pc;
            default: ;
        endcase
    end

    // a pending result with a memory request is always a read, with the load marked pending
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[139:138] == StPending && o_m_axis_tdata[33:32] != MemNone
        |-> o_m_axis_tdata[33:32] == MemRead && r_ld_pend)
        else $error("load request without pending load");

    // r0 is never reported as written
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[100] |-> o_m_axis_tdata[105:101] != 5'd0)
        else $error("write to r0 reported");

    // the result stays put while stalled
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    // input is never taken while a result is outstanding
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !i_s_axis_tready)
        else $error("input accepted with result pending");

endmodule
